@@ design/lfs_pkg.sv @@
// shared types and constants for the led frame sequencer
`default_nettype none
package lfs_pkg;

    localparam int LEVEL_W = 16;
    localparam int LATCH_W = 5;

    typedef enum logic [2:0] {
        KIND_SET_CH   = 3'd0,
        KIND_SET_ALL  = 3'd1,
        KIND_GAIN     = 3'd2,
        KIND_RES      = 3'd3,
        KIND_CTRL_WR  = 3'd4,
        KIND_SWITCH   = 3'd5,
        KIND_READ_CH  = 3'd6
    } t_kind;

    localparam logic [LATCH_W-1:0] LATCH_DATA   = 5'd4;
    localparam logic [LATCH_W-1:0] LATCH_GLOBAL = 5'd6;
    localparam logic [LATCH_W-1:0] LATCH_CTRL   = 5'd7;
    localparam logic [LATCH_W-1:0] LATCH_SWITCH = 5'd1;

    localparam logic [LEVEL_W-1:0] GAIN_MASK   = 16'h007F;
    localparam logic [LEVEL_W-1:0] TOP_BIT     = 16'h8000;
    localparam logic [LEVEL_W-1:0] SWITCH_WORD = 16'hFFFF;
    localparam logic [LEVEL_W-1:0] CTRL_RESET  = 16'h007F;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 16'h0001;

    typedef struct packed {
        logic               frame_valid;
        logic [LEVEL_W-1:0] frame_word;
        logic [LATCH_W-1:0] latch_clocks;
        logic [LEVEL_W-1:0] read_value;
        logic               error;
        logic               last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        logic       pop;
    } t_fifo_st;

endpackage
`default_nettype wire

@@ design/lfs_if.sv @@
// request and result channel interfaces
`default_nettype none
interface lfs_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [7:0]  channel;
    logic [15:0] value;

    modport source (output valid, output kind, output channel, output value, input ready);
    modport sink   (input valid, input kind, input channel, input value, output ready);
endinterface

interface lfs_res_if;
    logic        valid;
    logic        ready;
    logic        frame_valid;
    logic [15:0] frame_word;
    logic [4:0]  latch_clocks;
    logic [15:0] read_value;
    logic        error;
    logic        last;

    modport source (output valid, output frame_valid, output frame_word,
                    output latch_clocks, output read_value, output error,
                    output last, input ready);
    modport sink   (input valid, input frame_valid, input frame_word,
                    input latch_clocks, input read_value, input error,
                    input last, output ready);
endinterface
`default_nettype wire

@@ design/led_driver_frame_sequencer.sv @@
// top level: led driver frame sequencer with channel level store
`default_nettype none
// Holds CHANNELS channel levels in a small ram and a control word in a register,
// and turns each request into 16-bit shift frames with a latch length. A level
// update (one channel or all) sends channels CHANNELS-1 down to 0, one frame per
// cycle as fast as the ram read port and the two-entry result queue allow.
// Control, gain, resolution and switch requests give one frame, a channel read
// pushes the level into the result queue in the cycle after the ram read, an
// out-of-range channel gives one error result. A set-all is a broadcast register
// plus per-channel written flags, so it needs no ram sweep and there is no
// clearing pass after reset.
module led_driver_frame_sequencer #(
    parameter int CHANNELS = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lfs_req_if.sink   i_req,
    lfs_res_if.source o_res
);
    import lfs_pkg::*;

    localparam int IW = $clog2(CHANNELS);
    localparam logic [IW-1:0] LAST_IDX = IW'(CHANNELS - 1);

    typedef enum logic {ST_IDLE, ST_SEND} t_state;

    t_state             r_state;
    logic [IW-1:0]      r_idx;
    logic [LEVEL_W-1:0] r_ctrl, n_ctrl;
    logic [LEVEL_W-1:0] r_bcast;
    logic [CHANNELS-1:0] r_written;
    logic               r_inflight;
    logic               r_pend_read;
    logic               r_pend_hit;
    logic [LATCH_W-1:0] r_pend_latch;
    logic               r_pend_last;

    t_fifo_st           fifo_st;
    t_result            push_data, imm_res, pend_res;
    logic               push, imm_push;
    logic               accept, ch_ok, space, issue;
    logic [2:0]         occ;
    logic [IW-1:0]      ch_idx;
    logic               we, re;
    logic [IW-1:0]      raddr;
    logic [LEVEL_W-1:0] rdata, level;

    assign accept = i_req.valid && i_req.ready;
    assign ch_ok  = (i_req.channel < 8'(CHANNELS));
    assign ch_idx = i_req.channel[IW-1:0];
    assign space  = (fifo_st.count != 2'd2) || fifo_st.pop;
    assign occ    = {1'b0, fifo_st.count} - {2'b0, fifo_st.pop} + {2'b0, r_inflight};
    assign issue  = (r_state == ST_SEND) && (occ < 3'd2);

    assign i_req.ready = (r_state == ST_IDLE) && !r_inflight && space;

    lfs_ram #(.WIDTH(LEVEL_W), .DEPTH(CHANNELS)) u_levels (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (ch_idx),
        .i_wdata (i_req.value),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // result from the ram read issued last cycle
    always_comb begin
        level    = r_pend_hit ? rdata : r_bcast;
        pend_res = '0;
        pend_res.last = r_pend_read ? 1'b1 : r_pend_last;
        if (r_pend_read) begin
            pend_res.read_value = level;
        end else begin
            pend_res.frame_valid  = 1'b1;
            pend_res.frame_word   = level;
            pend_res.latch_clocks = r_pend_latch;
        end
    end

    always_comb begin
        we       = 1'b0;
        re       = issue;
        raddr    = r_idx;
        imm_push = 1'b0;
        imm_res  = '0;
        n_ctrl   = r_ctrl;
        if (accept) begin
            case (t_kind'(i_req.kind))
                KIND_SET_CH: begin
                    if (ch_ok) begin
                        we = 1'b1;
                    end else begin
                        imm_push      = 1'b1;
                        imm_res.error = 1'b1;
                        imm_res.last  = 1'b1;
                    end
                end
                KIND_READ_CH: begin
                    if (ch_ok) begin
                        re    = 1'b1;
                        raddr = ch_idx;
                    end else begin
                        imm_push      = 1'b1;
                        imm_res.error = 1'b1;
                        imm_res.last  = 1'b1;
                    end
                end
                KIND_GAIN, KIND_RES, KIND_CTRL_WR: begin
                    case (t_kind'(i_req.kind))
                        KIND_GAIN:
                            n_ctrl = (r_ctrl & ~GAIN_MASK) | (i_req.value & GAIN_MASK)
                                     | TOP_BIT;
                        KIND_RES:
                            n_ctrl = (i_req.value == '0) ? (r_ctrl & ~TOP_BIT)
                                                         : (r_ctrl | TOP_BIT);
                        default:
                            n_ctrl = i_req.value;
                    endcase
                    imm_push             = 1'b1;
                    imm_res.frame_valid  = 1'b1;
                    imm_res.frame_word   = n_ctrl;
                    imm_res.latch_clocks = LATCH_CTRL;
                    imm_res.last         = 1'b1;
                end
                KIND_SWITCH: begin
                    imm_push             = 1'b1;
                    imm_res.frame_valid  = 1'b1;
                    imm_res.frame_word   = SWITCH_WORD;
                    imm_res.latch_clocks = LATCH_SWITCH;
                    imm_res.last         = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign push      = r_inflight || imm_push;
    assign push_data = r_inflight ? pend_res : imm_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_idx      <= LAST_IDX;
            r_ctrl     <= CTRL_RESET;
            r_bcast    <= LEVEL_RESET;
            r_written  <= '0;
            r_inflight <= 1'b0;
        end else begin
            r_ctrl     <= n_ctrl;
            r_inflight <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (t_kind'(i_req.kind))
                            KIND_SET_CH: begin
                                if (ch_ok) begin
                                    r_written[ch_idx] <= 1'b1;
                                    r_idx             <= LAST_IDX;
                                    r_state           <= ST_SEND;
                                end
                            end
                            KIND_SET_ALL: begin
                                r_bcast   <= i_req.value;
                                r_written <= '0;
                                r_idx     <= LAST_IDX;
                                r_state   <= ST_SEND;
                            end
                            KIND_READ_CH: begin
                                if (ch_ok) begin
                                    r_inflight  <= 1'b1;
                                    r_pend_read <= 1'b1;
                                    r_pend_hit  <= r_written[ch_idx];
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_SEND: begin
                    if (issue) begin
                        r_inflight   <= 1'b1;
                        r_pend_read  <= 1'b0;
                        r_pend_hit   <= r_written[r_idx];
                        r_pend_last  <= (r_idx == '0);
                        r_pend_latch <= (r_idx == '0) ? LATCH_GLOBAL : LATCH_DATA;
                        if (r_idx == '0) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx - 1'b1;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    lfs_out_fifo u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_data),
        .o_status (fifo_st),
        .o_res    (o_res)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (fifo_st.count != 2'd2) || fifo_st.pop)
        else $error("result queue overflow");

    a_set_all_sends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.kind == KIND_SET_ALL) |=> (r_state == ST_SEND))
        else $error("set-all did not start frame sequence");

    a_last_frame_latch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.frame_valid && o_res.latch_clocks == LATCH_DATA)
        |-> !o_res.last)
        else $error("data latch frame marked last");

    a_single_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight |-> !imm_push)
        else $error("ram result and direct result pushed together");

endmodule
`default_nettype wire

@@ design/lfs_ram.sv @@
// generic single-write single-read ram with registered read
`default_nettype none
module lfs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ design/lfs_out_fifo.sv @@
// two-entry result queue driving the result channel
`default_nettype none
module lfs_out_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire lfs_pkg::t_result i_data,
    output lfs_pkg::t_fifo_st     o_status,
    lfs_res_if.source             o_res
);
    import lfs_pkg::*;

    t_result    r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic       pop;
    t_result    head;

    assign pop  = o_res.valid && o_res.ready;
    assign head = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_data;
                r_wptr        <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, pop};
        end
    end

    assign o_res.valid        = (r_count != 2'd0);
    assign o_res.frame_valid  = head.frame_valid;
    assign o_res.frame_word   = head.frame_word;
    assign o_res.latch_clocks = head.latch_clocks;
    assign o_res.read_value   = head.read_value;
    assign o_res.error        = head.error;
    assign o_res.last         = head.last;

    assign o_status.count = r_count;
    assign o_status.pop   = pop;

endmodule
`default_nettype wire
